// ----- hdl/fprfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprfa_pkg - shared types and constants
// Access codes, field widths and control/status constants for the FPU
// register file access block and its checker.
// ----------------------------------------------------------------------------
package fprfa_pkg;

  localparam int unsigned NUM_FPR    = 32;
  localparam int unsigned FPR_W      = 64;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CSR_W      = 25;
  localparam int unsigned IN_DATA_W  = 72;  // reg_index + write_data, padded to bytes
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FPR_W-1:0] fpr_t;
  typedef logic [CSR_W-1:0] csr_t;

  typedef enum logic [2:0] {
    ACT_RD_WORD = 3'd0,
    ACT_RD_DBL  = 3'd1,
    ACT_WR_WORD = 3'd2,
    ACT_WR_DBL  = 3'd3,
    ACT_RD_CTRL = 3'd4,
    ACT_WR_CTRL = 3'd5
  } action_t;

  // Configuration register indexes (taken from paddr bit 2)
  localparam logic CFG_WIDE_MODE  = 1'b0;
  localparam logic CFG_COP_USABLE = 1'b1;

  // Control register numbers and values
  localparam idx_t        CTRL_ID_INDEX     = 5'd0;
  localparam idx_t        CTRL_STATUS_INDEX = 5'd31;
  localparam logic [31:0] CTRL_WRITE_MASK   = 32'h0183_FFFF;
  localparam logic [31:0] CTRL_ID_VALUE     = 32'h0000_0A00;
  localparam int unsigned UNIMPL_BIT        = 17;
  localparam int unsigned CAUSE_LSB         = 12;
  localparam int unsigned ENABLE_LSB        = 7;
  localparam int unsigned CAUSE_W           = 5;

endpackage

// ----- hdl/fpu_register_file_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpu_register_file_access - coprocessor-1 register file access
// Path: an accepted item goes through the input register, then the result
// register, and shows on out_* from there; it is held while the result side
// is stalled. Throughput: one item per cycle when the result side is not
// stalled; the register array update and the result are both produced in
// the single pass after the input register.
// Reset: synchronous, active low; clears all 32 registers, the status word,
// the pipeline valids, and sets wide_mode 0 and cop_usable 1.
// ----------------------------------------------------------------------------
module fpu_register_file_access (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fprfa_pkg::IN_DATA_W-1:0]    in_tdata,   // [4:0] reg_index, [68:5] write_data
  input  logic [fprfa_pkg::IN_USER_W-1:0]    in_tuser,   // [2:0] action
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fprfa_pkg::OUT_DATA_W-1:0]   out_tdata,  // [63:0] read_data
  output logic [fprfa_pkg::OUT_USER_W-1:0]   out_tuser,  // [0] unusable_fault, [1] fp_exception
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fprfa_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [fprfa_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [fprfa_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import fprfa_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic wide_mode_r;
  logic cop_usable_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  // Only bit 2 of the address selects a register; the low bits are byte lanes.
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_mode_r  <= 1'b0;
      cop_usable_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        CFG_WIDE_MODE:  wide_mode_r  <= cfg_pwdata[0];
        CFG_COP_USABLE: cop_usable_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      CFG_WIDE_MODE:  cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, wide_mode_r};
      CFG_COP_USABLE: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, cop_usable_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the input register advances whenever the result register is
  // free or being emptied this cycle.
  // --------------------------------------------------------------------------
  logic    s1_valid_r;
  action_t s1_act_r;
  idx_t    s1_idx_r;
  fpr_t    s1_data_r;

  logic out_valid_r;
  fpr_t out_data_r;
  logic out_fault_r;
  logic out_fpe_r;

  logic advance;
  logic commit;

  assign advance   = !out_valid_r || out_tready;
  assign commit    = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Payload of the input register: load on every accepted item, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_act_r  <= action_t'(in_tuser[2:0]);
      s1_idx_r  <= in_tdata[IDX_W-1:0];
      s1_data_r <= in_tdata[IDX_W +: FPR_W];
    end
  end

  // --------------------------------------------------------------------------
  // Register array and status word
  // --------------------------------------------------------------------------
  fpr_t fpr_r [NUM_FPR];
  csr_t csr_r;

  // Paired mode: an odd index names the high word of the even register below.
  logic hi_half;
  idx_t pair_idx;
  idx_t word_idx;
  idx_t dbl_idx;
  fpr_t word_old;
  fpr_t dbl_old;
  logic [31:0] word_rd;

  assign hi_half  = !wide_mode_r && s1_idx_r[0];
  assign pair_idx = {s1_idx_r[IDX_W-1:1], 1'b0};
  assign word_idx = hi_half ? pair_idx : s1_idx_r;
  assign dbl_idx  = wide_mode_r ? s1_idx_r : pair_idx;
  assign word_old = fpr_r[word_idx];
  assign dbl_old  = fpr_r[dbl_idx];
  assign word_rd  = hi_half ? word_old[63:32] : word_old[31:0];

  // Status word after a control write, and the exception test on it
  logic [31:0] csr_wr_full;
  csr_t        csr_nxt;
  logic [CAUSE_W-1:0] cause;
  logic [CAUSE_W-1:0] enable;
  logic               fpe_hit;

  assign csr_wr_full = s1_data_r[31:0] & CTRL_WRITE_MASK;
  assign csr_nxt     = csr_wr_full[CSR_W-1:0];
  assign cause       = csr_nxt[CAUSE_LSB +: CAUSE_W];
  assign enable      = csr_nxt[ENABLE_LSB +: CAUSE_W];
  assign fpe_hit     = csr_nxt[UNIMPL_BIT] || |(cause & enable);

  // Result and write decode
  logic fpr_we;
  idx_t fpr_waddr;
  fpr_t fpr_wr_nxt;
  logic csr_we;
  fpr_t rd_nxt;
  logic fault_nxt;
  logic fpe_nxt;

  always_comb begin
    fpr_we     = 1'b0;
    fpr_waddr  = dbl_idx;
    fpr_wr_nxt = s1_data_r;
    csr_we     = 1'b0;
    rd_nxt     = '0;
    fault_nxt  = 1'b0;
    fpe_nxt    = 1'b0;
    case (s1_act_r)
      ACT_RD_WORD: begin
        if (!cop_usable_r) fault_nxt = 1'b1;
        else rd_nxt = {{32{word_rd[31]}}, word_rd};
      end
      ACT_RD_DBL: begin
        if (!cop_usable_r) fault_nxt = 1'b1;
        else rd_nxt = dbl_old;
      end
      ACT_WR_WORD: begin
        if (!cop_usable_r) begin
          fault_nxt = 1'b1;
        end else begin
          fpr_we     = 1'b1;
          fpr_waddr  = word_idx;
          // Merge the new word into the half it names, keep the other half.
          fpr_wr_nxt = hi_half ? {s1_data_r[31:0], word_old[31:0]}
                               : {word_old[63:32], s1_data_r[31:0]};
        end
      end
      ACT_WR_DBL: begin
        if (!cop_usable_r) fault_nxt = 1'b1;
        else fpr_we = 1'b1;
      end
      ACT_RD_CTRL: begin
        // Control accesses ignore cop_usable.
        if (s1_idx_r == CTRL_ID_INDEX)
          rd_nxt = {32'b0, CTRL_ID_VALUE};
        else if (s1_idx_r == CTRL_STATUS_INDEX)
          rd_nxt = {{(FPR_W-CSR_W){1'b0}}, csr_r};
      end
      ACT_WR_CTRL: begin
        // Only the status word is writable; the ID register drops writes.
        if (s1_idx_r == CTRL_STATUS_INDEX) begin
          csr_we  = 1'b1;
          fpe_nxt = fpe_hit;
        end
      end
      default: ;
    endcase
  end

  // State changes only when the item moves into the result register, so the
  // next item in the input register already sees them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FPR; i++) fpr_r[i] <= '0;
      csr_r <= '0;
    end else if (commit) begin
      if (fpr_we) fpr_r[fpr_waddr] <= fpr_wr_nxt;
      if (csr_we) csr_r <= csr_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold while stalled, advance otherwise.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r  <= rd_nxt;
      out_fault_r <= fault_nxt;
      out_fpe_r   <= fpe_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_fpe_r, out_fault_r};

endmodule

// ----- hdl/fprfa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprfa_checker - port-level checks
// Watches the result channel of the FPU register file access block.
// ----------------------------------------------------------------------------
module fprfa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [fprfa_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [fprfa_pkg::OUT_USER_W-1:0]  out_tuser
);
  import fprfa_pkg::*;

  // No result straight after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid directly after reset");

  // Stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A refused access never reports an exception and returns no data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && out_tdata == '0)
    else $error("refused access with data or exception");

  // An exception only comes from a control write, which returns no data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0)
    else $error("exception result with read data");

endmodule

bind fpu_register_file_access fprfa_checker u_fprfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
